// ===== rtl/rabs_pkg.sv =====
// shared types, widths and constants of the running average background subtractor
package rabs_pkg;

    // geometry of the background store
    localparam int MAX_PIXELS    = 131072;
    localparam int FRACTION_BITS = 16;
    localparam int PIX_W         = 8;
    localparam int ACC_W         = PIX_W + FRACTION_BITS;
    localparam int WORD_W        = ACC_W + 1;
    localparam int ADDR_W        = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int POS_W         = $clog2(MAX_PIXELS + 1);

    // learning rate, unsigned 1.16 with a ceiling of one
    localparam int RATE_BITS = 16;
    localparam int RATE_W    = RATE_BITS + 1;
    localparam int RATE_HALF = 1 << (RATE_BITS - 1);
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_BITS;

    // blend product: signed delta times signed rate
    localparam int PROD_W = (ACC_W + 1) + (RATE_W + 1);

    // background rounding
    localparam int FRAC_HALF = 1 << (FRACTION_BITS - 1);

    // presence sum
    localparam int SUM_W = 25;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // configuration
    localparam int THR_W      = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(26);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_LEARNING_RATE = 2'd1,
        REG_IGNORE_FG     = 2'd2,
        REG_DIFF_MODE     = 2'd3
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ABSOLUTE = 2'd0,
        MODE_LIGHTER  = 2'd1,
        MODE_DARKER   = 2'd2
    } diff_mode_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [RATE_W-1:0] learning_rate;
        logic              ignore_foreground;
        logic [MODE_W-1:0] difference_mode;
    } cfg_t;

    // input transaction
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             end_of_frame;
        logic             restart_learning;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [PIX_W-1:0] difference;
        logic             foreground_mask;
        logic [PIX_W-1:0] background_value;
        logic             frame_done;
        logic [SUM_W-1:0] presence_sum;
        logic             overflow;
    } out_item_t;

    // per-stage item tag carried along the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              eof;
        logic              seed;
        logic              in_store;
        logic [ADDR_W-1:0] addr;
    } tag_t;

    // classification of the item in the last stage
    typedef struct packed {
        logic [PIX_W-1:0] difference;
        logic             mask;
        logic [PIX_W-1:0] background;
    } class_t;

    // stage load enables
    typedef struct packed {
        logic load2;
        logic load3;
    } stage_ctrl_t;

endpackage

// ===== rtl/rabs_store.sv =====
// background and prior mask store, one write and one registered read port
module rabs_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [rabs_pkg::ADDR_W-1:0] rd_addr,
    output logic [rabs_pkg::WORD_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [rabs_pkg::ADDR_W-1:0] wr_addr,
    input  logic [rabs_pkg::WORD_W-1:0] wr_data
);
    import rabs_pkg::*;

    logic [WORD_W-1:0] mem [MAX_PIXELS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rabs_learn.sv =====
// blend stages: delta times rate, then rounding and background select
module rabs_learn (
    input  logic                        clk,
    input  rabs_pkg::cfg_t              cfg,
    input  rabs_pkg::stage_ctrl_t       ctrl,
    input  logic [rabs_pkg::WORD_W-1:0] rd_word,
    input  rabs_pkg::tag_t              tag1,
    input  rabs_pkg::tag_t              tag2,
    output logic [rabs_pkg::ACC_W-1:0]  acc3
);
    import rabs_pkg::*;

    logic [RATE_W-1:0]        rate1;
    logic [ACC_W-1:0]         acc1;
    logic [ACC_W-1:0]         p1;
    logic signed [ACC_W:0]    delta1;
    logic signed [RATE_W:0]   rate_s1;
    logic signed [PROD_W-1:0] prod1;
    logic                     learn1;

    logic signed [PROD_W-1:0] prod2_reg;
    logic [ACC_W-1:0]         acc2_reg;
    logic                     learn2_reg;
    logic signed [PROD_W-1:0] step2;
    logic [ACC_W-1:0]         blend2;
    logic [ACC_W-1:0]         acc3_next;
    logic [ACC_W-1:0]         acc3_reg;

    // stage 1: clamp rate, form delta, multiply
    always_comb
    begin
        rate1   = (cfg.learning_rate > RATE_ONE) ? RATE_ONE : cfg.learning_rate;
        acc1    = rd_word[ACC_W-1:0];
        p1      = {tag1.pixel, {FRACTION_BITS{1'b0}}};
        delta1  = $signed({1'b0, p1}) - $signed({1'b0, acc1});
        rate_s1 = $signed({1'b0, rate1});
        prod1   = delta1 * rate_s1;
        learn1  = !tag1.seed && !(cfg.ignore_foreground && rd_word[ACC_W]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            prod2_reg  <= prod1;
            acc2_reg   <= acc1;
            learn2_reg <= learn1;
        end
    end

    // stage 2: round the step, add, pick seed, blend or hold
    always_comb
    begin
        step2  = (prod2_reg + PROD_W'(RATE_HALF)) >>> RATE_BITS;
        blend2 = acc2_reg + step2[ACC_W-1:0];
        if (tag2.seed)
        begin
            acc3_next = {tag2.pixel, {FRACTION_BITS{1'b0}}};
        end
        else if (learn2_reg)
        begin
            acc3_next = blend2;
        end
        else
        begin
            acc3_next = acc2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load3)
        begin
            acc3_reg <= acc3_next;
        end
    end

    assign acc3 = acc3_reg;

endmodule

// ===== rtl/rabs_classify.sv =====
// rounded background, difference per mode and foreground decision
module rabs_classify (
    input  rabs_pkg::cfg_t             cfg,
    input  logic [rabs_pkg::ACC_W-1:0] acc,
    input  rabs_pkg::tag_t             tag,
    output rabs_pkg::class_t           result
);
    import rabs_pkg::*;

    logic [ACC_W:0]               rsum;
    logic [ACC_W-FRACTION_BITS:0] rq;
    logic [PIX_W-1:0]             bg;
    logic [PIX_W-1:0]             up;
    logic [PIX_W-1:0]             down;
    logic [PIX_W-1:0]             diff;

    // round to nearest and cap at full scale
    always_comb
    begin
        rsum = {1'b0, acc} + (ACC_W + 1)'(FRAC_HALF);
        rq   = rsum[ACC_W:FRACTION_BITS];
        bg   = rq[PIX_W] ? {PIX_W{1'b1}} : rq[PIX_W-1:0];
    end

    // difference by mode
    always_comb
    begin
        up   = (tag.pixel > bg) ? tag.pixel - bg : '0;
        down = (bg > tag.pixel) ? bg - tag.pixel : '0;
        case (cfg.difference_mode)
            MODE_LIGHTER: diff = up;
            MODE_DARKER:  diff = down;
            default:      diff = up | down;
        endcase
    end

    // pixels beyond the store pass through
    always_comb
    begin
        if (tag.in_store)
        begin
            result.difference = diff;
            result.mask       = diff > cfg.threshold;
            result.background = bg;
        end
        else
        begin
            result.difference = '0;
            result.mask       = 1'b0;
            result.background = tag.pixel;
        end
    end

endmodule

// ===== rtl/rabs_output.sv =====
// result register, frame difference total and output handshake
module rabs_output (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stage_valid,
    input  rabs_pkg::tag_t      tag,
    input  rabs_pkg::class_t    cls,
    output logic                load_ok,
    output logic                result_valid,
    input  logic                result_ready,
    output rabs_pkg::out_item_t result
);
    import rabs_pkg::*;

    logic             valid_reg;
    out_item_t        result_reg;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_sat;
    logic [SUM_W:0]   total_wide;
    logic             move;

    assign load_ok = !valid_reg || result_ready;
    assign move    = stage_valid && load_ok;

    // saturating add of this pixel's difference
    always_comb
    begin
        total_wide = {1'b0, total_reg} + (SUM_W + 1)'(cls.difference);
        total_sat  = total_wide[SUM_W] ? SUM_MAX : total_wide[SUM_W-1:0];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (load_ok)
            begin
                valid_reg <= stage_valid;
            end
            if (move)
            begin
                total_reg <= tag.eof ? '0 : total_sat;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            result_reg.difference       <= cls.difference;
            result_reg.foreground_mask  <= cls.mask;
            result_reg.background_value <= cls.background;
            result_reg.frame_done       <= tag.eof;
            result_reg.presence_sum     <= tag.eof ? total_sat : '0;
            result_reg.overflow         <= !tag.in_store;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/running_average_background_subtract.sv =====
// top level of the running average background subtractor
//
//  channel   direction  handshake                      payload
//  sample    in         sample_valid / sample_ready    pixel, end_of_frame, restart_learning
//  result    out        result_valid / result_ready    difference, mask, background, sum
//  cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// one pixel per cycle sustained while no result stalls and no pixel waits as below.
// store read at accept, blend multiply, round/select, classify with store write-back.
// a pixel waits while an earlier pixel of the same entry is still in flight, which
// only happens for frames shorter than four pixels.
// the store has no reset; position, seeding flag and frame total reset at once.
// a stalled result holds the pipeline; a non-waiting pixel is taken once stage 1 frees up.
module running_average_background_subtract (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  rabs_pkg::in_item_t               sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output rabs_pkg::out_item_t              result,
    input  logic                             cfg_we,
    input  logic [rabs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rabs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rabs_pkg::*;

    cfg_t              cfg_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              seeding_reg;
    logic              seeding_next;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    tag_t              t1_reg;
    tag_t              t2_reg;
    tag_t              t3_reg;
    tag_t              t0;
    logic              in_store0;
    logic              hazard;
    logic              accept;
    logic              en1;
    logic              en2;
    logic              en3;
    logic              out_ok;
    stage_ctrl_t       ctrl;
    logic [WORD_W-1:0] rd_word;
    logic [ACC_W-1:0]  acc3;
    class_t            cls;
    logic              wr_en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold         <= THR_RESET;
            cfg_reg.learning_rate     <= RATE_RESET;
            cfg_reg.ignore_foreground <= 1'b0;
            cfg_reg.difference_mode   <= MODE_ABSOLUTE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:     cfg_reg.threshold         <= cfg_data[THR_W-1:0];
                REG_LEARNING_RATE: cfg_reg.learning_rate     <= cfg_data[RATE_W-1:0];
                REG_IGNORE_FG:     cfg_reg.ignore_foreground <= cfg_data[0];
                REG_DIFF_MODE:     cfg_reg.difference_mode   <= cfg_data[MODE_W-1:0];
                default:           ;
            endcase
        end
    end

    // incoming pixel tag
    always_comb
    begin
        in_store0   = pos_reg < POS_W'(MAX_PIXELS);
        t0.pixel    = sample.pixel;
        t0.eof      = sample.end_of_frame;
        t0.seed     = seeding_reg || ((pos_reg == '0) && sample.restart_learning);
        t0.in_store = in_store0;
        t0.addr     = pos_reg[ADDR_W-1:0];
    end

    // interlock on an entry still in flight
    assign hazard = in_store0 &&
                    ((v1_reg && t1_reg.in_store && (t1_reg.addr == t0.addr)) ||
                     (v2_reg && t2_reg.in_store && (t2_reg.addr == t0.addr)) ||
                     (v3_reg && t3_reg.in_store && (t3_reg.addr == t0.addr)));

    // stage enables
    assign en3          = !v3_reg || out_ok;
    assign en2          = !v2_reg || en3;
    assign en1          = !v1_reg || en2;
    assign sample_ready = en1 && !hazard;
    assign accept       = sample_valid && sample_ready;
    assign ctrl.load2   = en2;
    assign ctrl.load3   = en3;
    assign wr_en        = v3_reg && out_ok && t3_reg.in_store;

    // frame position and seeding
    always_comb
    begin
        pos_next     = pos_reg;
        seeding_next = seeding_reg;
        if (accept)
        begin
            if (sample.end_of_frame)
            begin
                pos_next = '0;
            end
            else if (in_store0)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            seeding_next = sample.end_of_frame ? 1'b0 : t0.seed;
        end
    end

    // pipeline control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            seeding_reg <= 1'b1;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            seeding_reg <= seeding_next;
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // tag pipeline
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            t1_reg <= t0;
        end
        if (en2)
        begin
            t2_reg <= t1_reg;
        end
        if (en3)
        begin
            t3_reg <= t2_reg;
        end
    end

    rabs_store u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (t0.addr),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (t3_reg.addr),
        .wr_data ({cls.mask, acc3})
    );

    rabs_learn u_learn (
        .clk     (clk),
        .cfg     (cfg_reg),
        .ctrl    (ctrl),
        .rd_word (rd_word),
        .tag1    (t1_reg),
        .tag2    (t2_reg),
        .acc3    (acc3)
    );

    rabs_classify u_classify (
        .cfg    (cfg_reg),
        .acc    (acc3),
        .tag    (t3_reg),
        .result (cls)
    );

    rabs_output u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (v3_reg),
        .tag          (t3_reg),
        .cls          (cls),
        .load_ok      (out_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/rabs_checker.sv =====
// port-level checks of the background subtractor, bound to the top level
module rabs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_ready,
    input rabs_pkg::in_item_t  sample,
    input logic                result_valid,
    input logic                result_ready,
    input rabs_pkg::out_item_t result
);
    import rabs_pkg::*;

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // pixels beyond the store carry no difference and no mask
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            (result.difference == '0) && !result.foreground_mask)
        else $error("overflow result with difference or mask");

    // the frame total shows only at end of frame
    a_sum_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.frame_done |-> (result.presence_sum == '0))
        else $error("presence sum outside end of frame");

    // a zero difference is never foreground
    a_mask_needs_diff: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.difference == '0) |-> !result.foreground_mask)
        else $error("foreground mask with zero difference");

endmodule

bind running_average_background_subtract rabs_checker u_rabs_checker (.*);

// ===== tb/background_subtract_checker.sv =====
// checker for the running average background subtractor: predicts each result and compares
module background_subtract_checker
    import rabs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  in_item_t              sample,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [THR_W-1:0]  threshold_q;
    logic [RATE_W-1:0] rate_q;
    logic              ignore_fg_q;
    logic [MODE_W-1:0] mode_q;

    // predicted block state
    logic [ACC_W-1:0] bg_acc [MAX_PIXELS];
    logic             mask_hist [MAX_PIXELS];
    int               position;
    bit               seeding;
    int unsigned      frame_total;

    out_item_t expected_results [$];
    out_item_t want;
    int        errors;
    int        checked;

    // one pixel through the background model, updating the predicted state
    function automatic out_item_t subtract_pixel(input in_item_t it);
        out_item_t         r;
        longint unsigned   acc_now;
        longint unsigned   pix_fx;
        longint unsigned   w;
        longint unsigned   rounded;
        int                bg;
        int                px;
        int                diff;
        logic [ADDR_W-1:0] a;
        r = '0;
        px = int'(it.pixel);
        diff = 0;
        r.background_value = it.pixel;
        r.frame_done = it.end_of_frame;
        if (position == 0 && it.restart_learning)
            seeding = 1'b1;
        if (position < MAX_PIXELS)
        begin
            a = position[ADDR_W-1:0];
            pix_fx = longint'(px) << FRACTION_BITS;
            acc_now = longint'(bg_acc[a]);
            if (seeding)
                acc_now = pix_fx;
            else if (!(ignore_fg_q && mask_hist[a]))
            begin
                w = (rate_q > RATE_ONE) ? longint'(RATE_ONE) : longint'(rate_q);
                acc_now = (acc_now * (longint'(RATE_ONE) - w) + pix_fx * w + RATE_HALF)
                          >> RATE_BITS;
            end
            bg_acc[a] = ACC_W'(acc_now);
            rounded = (acc_now + FRAC_HALF) >> FRACTION_BITS;
            bg = (rounded > 255) ? 255 : int'(rounded);
            // difference per mode, unused code behaves as absolute
            if (mode_q == MODE_LIGHTER)
                diff = (px > bg) ? px - bg : 0;
            else if (mode_q == MODE_DARKER)
                diff = (bg > px) ? bg - px : 0;
            else
                diff = (px > bg) ? px - bg : bg - px;
            r.difference = PIX_W'(diff);
            r.foreground_mask = (diff > int'(threshold_q));
            r.background_value = PIX_W'(bg);
            mask_hist[a] = r.foreground_mask;
            position = position + 1;
        end
        else
        begin
            // beyond the store: pass through, flagged
            r.overflow = 1'b1;
            position = MAX_PIXELS;
        end
        frame_total = frame_total + diff;
        if (frame_total > SUM_MAX)
            frame_total = SUM_MAX;
        if (it.end_of_frame)
        begin
            r.presence_sum = SUM_W'(frame_total);
            position = 0;
            frame_total = 0;
            seeding = 1'b0;
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_v, got_v);
        end
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_q = THR_RESET;
            rate_q      = RATE_RESET;
            ignore_fg_q = 1'b0;
            mode_q      = MODE_ABSOLUTE;
            position    = 0;
            seeding     = 1'b1;
            frame_total = 0;
            expected_results.delete();
            errors      = 0;
            checked     = 0;
            fail_count  <= 0;
            pending     <= 0;
            checked_count <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_THRESHOLD:     threshold_q = cfg_data[THR_W-1:0];
                    REG_LEARNING_RATE: rate_q      = cfg_data[RATE_W-1:0];
                    REG_IGNORE_FG:     ignore_fg_q = cfg_data[0];
                    REG_DIFF_MODE:     mode_q      = cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, actual %p",
                             $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    compare_field("difference", want.difference, result.difference);
                    compare_field("foreground_mask", want.foreground_mask,
                                  result.foreground_mask);
                    compare_field("background_value", want.background_value,
                                  result.background_value);
                    compare_field("frame_done", want.frame_done, result.frame_done);
                    compare_field("presence_sum", want.presence_sum, result.presence_sum);
                    compare_field("overflow", want.overflow, result.overflow);
                end
            end
            // sample transaction
            if (sample_valid && sample_ready)
                expected_results.push_back(subtract_pixel(sample));
            fail_count    <= errors;
            pending       <= expected_results.size();
            checked_count <= checked;
        end
    end

endmodule

// ===== tb/tb_running_average_background_subtract.sv =====
// top of the background subtractor testbench: clock, reset, stimulus and verdict
module tb_running_average_background_subtract;
    import rabs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // seeded frame covers every entry that the random frames reach
    localparam int SEED_LEN     = 64;
    localparam int RANDOM_ITEMS = 900;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    in_item_t              sample;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked_count;

    // no idling on either side while set
    bit steady = 1'b0;

    int pixels_sent;
    int frames_sent;
    int settings_used;
    int scene [64];

    running_average_background_subtract dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    background_subtract_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stalls at random about 12 percent of the time
    always @(posedge clk)
    begin
        result_ready <= steady || ($urandom_range(99) >= 12);
    end

    // hard stop
    initial
    begin
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // one pixel transaction, with an occasional gap before it
    task automatic push_pixel(input int px, input bit eof, input bit restart);
        if (!steady && $urandom_range(99) < 12)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{pixel: PIX_W'(px), end_of_frame: eof, restart_learning: restart};
        do @(posedge clk); while (!sample_ready);
        pixels_sent++;
    endtask

    // a whole frame from a fixed list, restart pulsed at one index
    task automatic send_list(input int px [$], input int restart_at);
        for (int i = 0; i < px.size(); i++)
            push_pixel(px[i], i == px.size() - 1, i == restart_at);
        frames_sent++;
    endtask

    // a frame drawn around the current scene, with foreground blobs and stray restarts
    task automatic send_scene_frame(input int len, input bit reseed);
        int v;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 15)
                v = $urandom_range(0, 255);
            else
                v = scene[i % 64] + $urandom_range(0, 6) - 3;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            push_pixel(v, i == len - 1, (i == 0) ? reseed : ($urandom_range(99) < 5));
        end
        frames_sent++;
    endtask

    // hold off until every result is back
    task automatic settle();
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int thr, input int rate, input bit ign,
                             input logic [MODE_W-1:0] mode);
        settle();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_LEARNING_RATE, CFG_DATA_W'(rate));
        write_reg(REG_IGNORE_FG, CFG_DATA_W'(ign));
        write_reg(REG_DIFF_MODE, CFG_DATA_W'(mode));
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        int random_items;
        int phase_goal;
        int len;
        int thr;
        int rate;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_THRESHOLD;
        cfg_data     <= '0;
        random_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame seeds; a restart in mid frame is ignored
        send_list({0, 255, 128, 1, 254, 127}, 3);
        send_list({255, 0, 128, 0, 255, 90}, 4);
        // lighter only, zero threshold, half rate, frames shorter than the pipeline
        configure(0, 32768, 1'b0, MODE_LIGHTER);
        send_list({10, 250, 128}, -1);
        send_list({255}, -1);
        send_list({0}, -1);
        // darker only, top threshold, rate above one, skip last frame's foreground
        configure(255, 131071, 1'b1, MODE_DARKER);
        send_list({0, 255, 17, 200, 128}, -1);
        // unused mode code, frozen learning, reseed by restart
        configure(10, 0, 1'b1, MODE_UNUSED);
        send_list({77, 255, 0}, 0);

        // reseed a longer frame with black at full rate, no idling on either side
        configure(26, 65536, 1'b0, MODE_ABSOLUTE);
        steady <= 1'b1;
        for (int i = 0; i < SEED_LEN; i++)
            push_pixel(0, i == SEED_LEN - 1, i == 0);
        frames_sent++;

        // full white frame over the frozen black background: every pixel at full difference
        configure(254, 0, 1'b1, MODE_ABSOLUTE);
        for (int i = 0; i < SEED_LEN; i++)
            push_pixel(255, i == SEED_LEN - 1, 1'b0);
        frames_sent++;
        settle();
        steady <= 1'b0;

        // random phases, each under its own register setting
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 5))
                0:       rate = 0;
                1:       rate = 65536;
                2:       rate = $urandom_range(65537, 131071);
                3:       rate = $urandom_range(1, 4095);
                4:       rate = 131071;
                default: rate = $urandom_range(0, 65535);
            endcase
            configure(thr, rate, 1'($urandom), MODE_W'($urandom_range(0, 3)));
            foreach (scene[i])
                scene[i] = $urandom_range(0, 255);
            phase_goal = random_items + $urandom_range(40, 120);
            while (random_items < phase_goal && random_items < RANDOM_ITEMS)
            begin
                len = ($urandom_range(99) < 20) ? $urandom_range(1, 3) : $urandom_range(4, 48);
                send_scene_frame(len, $urandom_range(99) < 15);
                random_items += len;
            end
        end

        // drain and verdict
        settle();
        repeat (12) @(posedge clk);
        $display("covered %0d pixel transactions in %0d frames over %0d register settings",
                 pixels_sent, frames_sent, settings_used);
        $display("%0d results checked, incl. short frames, full-rate reseeding and a white frame",
                 checked_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== running_average_background_subtract.f =====
rtl/rabs_pkg.sv
rtl/rabs_store.sv
rtl/rabs_learn.sv
rtl/rabs_classify.sv
rtl/rabs_output.sv
rtl/running_average_background_subtract.sv
rtl/rabs_checker.sv
tb/background_subtract_checker.sv
tb/tb_running_average_background_subtract.sv
